@@ rtl/olie_pkg.sv @@
`timescale 1ns / 1ps

package olie_pkg;

    // Default list capacity in words
    localparam int DEF_CAPACITY = 128;

    // Payload widths fixed by the request and response formats
    localparam int OP_W    = 2;
    localparam int POS_W   = 8;
    localparam int WORD_W  = 32;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_LOCATE = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

@@ rtl/olie_req_if.sv @@
`timescale 1ns / 1ps

// Request channel: one beat carries one list operation
interface olie_req_if;
    logic                                valid;
    logic                                ready;
    olie_pkg::t_op                       op;
    logic        [olie_pkg::POS_W-1:0]   position;
    logic signed [olie_pkg::WORD_W-1:0]  value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

@@ rtl/olie_rsp_if.sv @@
`timescale 1ns / 1ps

// Response channel: one beat per request
interface olie_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [olie_pkg::WORD_W-1:0]  read_value;
    logic        [olie_pkg::POS_W-1:0]   found_position;
    logic        [olie_pkg::POS_W-1:0]   count;

    modport source (output valid, output ok, output read_value, output found_position,
                    output count, input ready);
    modport sink   (input valid, input ok, input read_value, input found_position,
                    input count, output ready);
endinterface

@@ rtl/olie_word_ram.sv @@
`timescale 1ns / 1ps

// Word store: one write port, one read port with registered read data
module olie_word_ram #(
    parameter int DEPTH = olie_pkg::DEF_CAPACITY,
    parameter int AW    = $clog2(olie_pkg::DEF_CAPACITY)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [olie_pkg::WORD_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [olie_pkg::WORD_W-1:0] o_rd_data
);

    logic [olie_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

@@ rtl/ordered_list_insert_delete_engine.sv @@
`timescale 1ns / 1ps

// Array-backed list of up to CAPACITY signed 32-bit words with get, locate, insert and
// delete requests, one response beat per request. The store is a single-port-write,
// registered-read memory walked by one address counter and one comparator, one word
// per cycle. Locate stops at the first match, insert moves count-position+1 words and
// delete count-position. The request side is ready only when the sequencer is idle;
// a finished response sits in an output register, so the next request is taken while
// it waits. The count field reports the low eight bits of the word count.
module ordered_list_insert_delete_engine #(
    parameter int CAPACITY = olie_pkg::DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    olie_req_if.sink   i_req,
    olie_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > olie_pkg::POS_W) ? CW : olie_pkg::POS_W) + 1;

    olie_pkg::t_state r_state, n_state;
    olie_pkg::t_op    r_op, n_op;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_ins_addr, n_ins_addr;
    logic [olie_pkg::WORD_W-1:0] r_value, n_value;
    logic [AW-1:0]    r_rd_addr, n_rd_addr;
    logic [AW-1:0]    r_last, n_last;
    logic             r_more, n_more;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pend_addr, n_pend_addr;
    logic             r_ok, n_ok;
    logic [olie_pkg::WORD_W-1:0] r_rd_val, n_rd_val;
    logic [olie_pkg::POS_W-1:0]  r_found, n_found;

    logic             r_o_vld, n_o_vld;
    logic             r_o_ok, n_o_ok;
    logic [olie_pkg::WORD_W-1:0] r_o_rd, n_o_rd;
    logic [olie_pkg::POS_W-1:0]  r_o_found, n_o_found;
    logic [olie_pkg::POS_W-1:0]  r_o_count, n_o_count;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [olie_pkg::WORD_W-1:0] wr_data;
    logic [olie_pkg::WORD_W-1:0] rd_data;

    logic [XW-1:0]    pos_x, cnt_x, found_x, cnt_out_x;
    logic [AW-1:0]    pos_m1, cnt_m1, pos_a;
    logic             get_ok, ins_ok;

    olie_word_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (rd_data)
    );

    // Range checks on the incoming request
    always_comb begin
        pos_x   = XW'(i_req.position);
        cnt_x   = XW'(r_count);
        pos_m1  = AW'(pos_x - XW'(1));
        cnt_m1  = AW'(cnt_x - XW'(1));
        pos_a   = AW'(pos_x);
        get_ok  = (pos_x != '0) && (pos_x <= cnt_x);
        ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(CAPACITY));
        found_x = XW'(r_pend_addr) + XW'(1);
    end

    assign i_req.ready = (r_state == olie_pkg::ST_IDLE);

    // Sequencer: next state, walk counter and store writes
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_ins_addr  = r_ins_addr;
        n_value     = r_value;
        n_rd_addr   = r_rd_addr;
        n_last      = r_last;
        n_more      = r_more;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_ok        = r_ok;
        n_rd_val    = r_rd_val;
        n_found     = r_found;
        n_o_vld     = r_o_vld && !o_rsp.ready;
        n_o_ok      = r_o_ok;
        n_o_rd      = r_o_rd;
        n_o_found   = r_o_found;
        n_o_count   = r_o_count;
        wr_en       = 1'b0;
        wr_addr     = r_ins_addr;
        wr_data     = r_value;
        cnt_out_x   = XW'(r_count);

        unique case (r_state)
            olie_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.op;
                    n_value    = i_req.value;
                    n_ins_addr = pos_m1;
                    n_pend     = 1'b0;
                    n_ok       = 1'b0;
                    n_rd_val   = '0;
                    n_found    = '0;
                    n_more     = 1'b0;
                    n_state    = olie_pkg::ST_DONE;
                    unique case (i_req.op)
                        olie_pkg::OP_GET: begin
                            if (get_ok) begin
                                n_ok      = 1'b1;
                                n_rd_addr = pos_m1;
                                n_last    = pos_m1;
                                n_more    = 1'b1;
                                n_state   = olie_pkg::ST_WALK;
                            end
                        end
                        olie_pkg::OP_LOCATE: begin
                            if (r_count != '0) begin
                                n_rd_addr = '0;
                                n_last    = cnt_m1;
                                n_more    = 1'b1;
                                n_state   = olie_pkg::ST_WALK;
                            end
                        end
                        olie_pkg::OP_INSERT: begin
                            if (ins_ok) begin
                                n_ok      = 1'b1;
                                n_rd_addr = cnt_m1;
                                n_last    = pos_m1;
                                n_more    = (pos_x <= cnt_x);
                                n_state   = olie_pkg::ST_WALK;
                            end
                        end
                        olie_pkg::OP_DELETE: begin
                            if (get_ok) begin
                                n_ok      = 1'b1;
                                n_rd_addr = pos_a;
                                n_last    = cnt_m1;
                                n_more    = (pos_x < cnt_x);
                                n_state   = olie_pkg::ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            olie_pkg::ST_WALK: begin
                // issue one read per cycle
                if (r_more) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                    n_more      = (r_rd_addr != r_last);
                    if (r_op == olie_pkg::OP_INSERT) begin
                        n_rd_addr = r_rd_addr - AW'(1);
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                // consume the word read last cycle
                if (r_pend) begin
                    unique case (r_op)
                        olie_pkg::OP_GET: n_rd_val = rd_data;
                        olie_pkg::OP_LOCATE: begin
                            if (rd_data == r_value) begin
                                n_ok    = 1'b1;
                                n_found = found_x[olie_pkg::POS_W-1:0];
                                n_state = olie_pkg::ST_DONE;
                            end
                        end
                        olie_pkg::OP_INSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pend_addr + AW'(1);
                            wr_data = rd_data;
                        end
                        olie_pkg::OP_DELETE: begin
                            wr_en   = 1'b1;
                            wr_addr = r_pend_addr - AW'(1);
                            wr_data = rd_data;
                        end
                        default: ;
                    endcase
                end
                if (!r_more && !r_pend) begin
                    n_state = olie_pkg::ST_DONE;
                end
            end

            olie_pkg::ST_DONE: begin
                // commit and load the response once the output slot is free
                if (!r_o_vld || o_rsp.ready) begin
                    if (r_ok && (r_op == olie_pkg::OP_INSERT)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else if (r_ok && (r_op == olie_pkg::OP_DELETE)) begin
                        n_count = r_count - CW'(1);
                    end
                    cnt_out_x = XW'(n_count);
                    n_o_vld   = 1'b1;
                    n_o_ok    = r_ok;
                    n_o_rd    = r_rd_val;
                    n_o_found = r_found;
                    n_o_count = cnt_out_x[olie_pkg::POS_W-1:0];
                    n_state   = olie_pkg::ST_IDLE;
                end
            end

            default: n_state = olie_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olie_pkg::ST_IDLE;
            r_count <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_more  <= n_more;
            r_pend  <= n_pend;
            r_o_vld <= n_o_vld;
        end
    end

    // Working and response payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_ins_addr  <= n_ins_addr;
        r_value     <= n_value;
        r_rd_addr   <= n_rd_addr;
        r_last      <= n_last;
        r_pend_addr <= n_pend_addr;
        r_ok        <= n_ok;
        r_rd_val    <= n_rd_val;
        r_found     <= n_found;
        r_o_ok      <= n_o_ok;
        r_o_rd      <= n_o_rd;
        r_o_found   <= n_o_found;
        r_o_count   <= n_o_count;
    end

    assign o_rsp.valid          = r_o_vld;
    assign o_rsp.ok             = r_o_ok;
    assign o_rsp.read_value     = r_o_rd;
    assign o_rsp.found_position = r_o_found;
    assign o_rsp.count          = r_o_count;

    // Checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("word count above capacity");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olie_pkg::ST_IDLE) |-> !wr_en)
        else $error("store written while idle");

    a_count_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != olie_pkg::ST_DONE) |=> $stable(r_count))
        else $error("count changed outside commit");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_vld) |-> $past(r_state == olie_pkg::ST_DONE))
        else $error("response loaded outside commit");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == olie_pkg::ST_WALK) && r_pend) |-> (CW'(r_pend_addr) < r_count))
        else $error("walk read beyond stored words");

endmodule

@@ dv/tb_ordered_list_insert_delete_engine.sv @@
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete_engine;

    localparam int LIST_CAP    = olie_pkg::DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int BLOCK_ITEMS = 137;
    localparam int NUM_BLOCKS  = 10;

    // One request beat; pick_pos / pick_val defer the choice to the moment it is driven
    typedef struct {
        olie_pkg::t_op                      op;
        logic        [olie_pkg::POS_W-1:0]  position;
        logic signed [olie_pkg::WORD_W-1:0] value;
        bit                                 pick_pos;
        bit                                 pick_val;
        bit                                 drain;
    } t_list_req;

    typedef struct packed {
        logic                               ok;
        logic signed [olie_pkg::WORD_W-1:0] read_value;
        logic        [olie_pkg::POS_W-1:0]  found_position;
        logic        [olie_pkg::POS_W-1:0]  count;
    } t_list_rsp;

    logic i_clk;
    logic i_rst_n;

    olie_req_if req_if ();
    olie_rsp_if rsp_if ();

    ordered_list_insert_delete_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the list
    logic signed [olie_pkg::WORD_W-1:0] list_words [LIST_CAP];
    int                                 list_len;

    t_list_req req_backlog [$];
    t_list_rsp expected_rsp [$];

    int req_issued;
    int req_beats;
    int rsp_beats;
    int errors;
    int cycle_count;
    int gap_left;
    int quiet_beats;
    int hold_left;
    int calm_left;
    int long_holds;

    // Apply one request to the shadow list and return the response it should give
    function automatic t_list_rsp predict_list_op(input olie_pkg::t_op op,
                                                  input logic [olie_pkg::POS_W-1:0] pos,
                                                  input logic signed [olie_pkg::WORD_W-1:0] val);
        t_list_rsp rsp;
        int        p;
        int        j;
        rsp = '0;
        p   = int'(pos);
        case (op)
            olie_pkg::OP_GET: begin
                if (p >= 1 && p <= list_len) begin
                    rsp.read_value = list_words[p-1];
                    rsp.ok         = 1'b1;
                end
            end
            olie_pkg::OP_LOCATE: begin
                // first match wins
                for (j = 0; j < list_len && !rsp.ok; j++) begin
                    if (list_words[j] == val) begin
                        rsp.found_position = olie_pkg::POS_W'(j + 1);
                        rsp.ok             = 1'b1;
                    end
                end
            end
            olie_pkg::OP_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < LIST_CAP) begin
                    for (j = list_len; j >= p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p-1] = val;
                    list_len++;
                    rsp.ok = 1'b1;
                end
            end
            default: begin
                if (p >= 1 && p <= list_len) begin
                    for (j = p; j < list_len; j++)
                        list_words[j-1] = list_words[j];
                    list_len--;
                    rsp.ok = 1'b1;
                end
            end
        endcase
        rsp.count = olie_pkg::POS_W'(list_len);
        return rsp;
    endfunction

    // Word mix: wide random, small values for duplicates, small negatives, extremes
    function automatic logic signed [olie_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return $urandom_range(0, 15);
            8:             return -$signed($urandom_range(1, 16));
            default:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    task automatic queue_req(input olie_pkg::t_op op, input int pos,
                             input logic signed [olie_pkg::WORD_W-1:0] val,
                             input bit pick_pos, input bit pick_val, input bit drain);
        t_list_req item;
        item.op       = op;
        item.position = olie_pkg::POS_W'(pos);
        item.value    = val;
        item.pick_pos = pick_pos;
        item.pick_val = pick_val;
        item.drain    = drain;
        req_backlog.push_back(item);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Request driver: one beat at a time from the backlog, random gaps between beats
    always @(negedge i_clk) begin : req_driver
        t_list_req item;
        int        r;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!(req_if.valid && req_beats < req_issued)) begin
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (req_backlog.size() == 0 ||
                         (req_backlog[0].drain && expected_rsp.size() != 0)) begin
                req_if.valid <= 1'b0;
            end else begin
                item = req_backlog.pop_front();
                // resolve deferred fields against the current list
                if (item.pick_pos) begin
                    if (item.op == olie_pkg::OP_INSERT)
                        item.position = olie_pkg::POS_W'($urandom_range(1, list_len + 1));
                    else
                        item.position = (list_len == 0) ? olie_pkg::POS_W'(1) :
                                        olie_pkg::POS_W'($urandom_range(1, list_len));
                end
                if (item.pick_val && list_len > 0)
                    item.value = list_words[$urandom_range(0, list_len - 1)];
                req_if.op       <= item.op;
                req_if.position <= item.position;
                req_if.value    <= item.value;
                req_if.valid    <= 1'b1;
                req_issued++;
                // gap before the next beat: mostly none, some short, a few long
                if (quiet_beats > 0) begin
                    quiet_beats--;
                    gap_left = 0;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 2) begin
                        quiet_beats = $urandom_range(20, 60);
                        gap_left    = 0;
                    end else if (r < 60) begin
                        gap_left = 0;
                    end else if (r < 92) begin
                        gap_left = $urandom_range(1, 3);
                    end else begin
                        gap_left = $urandom_range(8, 60);
                    end
                end
            end
        end
    end

    // Request monitor: every accepted beat updates the shadow list
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            expected_rsp.push_back(predict_list_op(req_if.op, req_if.position, req_if.value));
            req_beats++;
        end
    end

    // Response ready: short random stalls, calm stretches, and two forced long hold-offs
    always @(negedge i_clk) begin : rsp_ready_gen
        int r;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if ((long_holds == 0 && rsp_beats >= 300) ||
                     (long_holds == 1 && rsp_beats >= 1000)) begin
            long_holds++;
            hold_left = 700;
            rsp_if.ready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            rsp_if.ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 999);
            if (r < 5) begin
                calm_left = $urandom_range(50, 200);
                rsp_if.ready <= 1'b1;
            end else if (r < 10) begin
                hold_left = $urandom_range(40, 150);
                rsp_if.ready <= 1'b0;
            end else if (r < 300) begin
                hold_left = $urandom_range(0, 3);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Response monitor: compare each beat with the oldest expectation
    always @(posedge i_clk) begin : rsp_monitor
        t_list_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_beats++;
            if (expected_rsp.size() == 0) begin
                errors++;
                $display("%0t: unexpected response beat: ok=%0d read_value=%0d found=%0d count=%0d",
                         $time, rsp_if.ok, rsp_if.read_value, rsp_if.found_position,
                         rsp_if.count);
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_if.ok !== want.ok) begin
                    errors++;
                    $display("%0t: ok mismatch, expected %0d actual %0d",
                             $time, want.ok, rsp_if.ok);
                end
                if (rsp_if.read_value !== want.read_value) begin
                    errors++;
                    $display("%0t: read_value mismatch, expected %0d actual %0d",
                             $time, want.read_value, rsp_if.read_value);
                end
                if (rsp_if.found_position !== want.found_position) begin
                    errors++;
                    $display("%0t: found_position mismatch, expected %0d actual %0d",
                             $time, want.found_position, rsp_if.found_position);
                end
                if (rsp_if.count !== want.count) begin
                    errors++;
                    $display("%0t: count mismatch, expected %0d actual %0d",
                             $time, want.count, rsp_if.count);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int            blk;
        int            k;
        int            r;
        int            w_get;
        int            w_loc;
        int            w_ins;
        olie_pkg::t_op op;
        i_rst_n = 1'b0;

        // Directed: empty list, bad positions, extremes, duplicates
        queue_req(olie_pkg::OP_GET,    1,   0,              0, 0, 0);
        queue_req(olie_pkg::OP_DELETE, 1,   0,              0, 0, 0);
        queue_req(olie_pkg::OP_LOCATE, 0,   0,              0, 0, 0);
        queue_req(olie_pkg::OP_INSERT, 0,   5,              0, 0, 0);  // position zero rejected
        queue_req(olie_pkg::OP_INSERT, 2,   5,              0, 0, 0);  // past end
        queue_req(olie_pkg::OP_INSERT, 1,   32'sh7FFF_FFFF, 0, 0, 0);
        queue_req(olie_pkg::OP_INSERT, 2,   32'sh8000_0000, 0, 0, 0);
        queue_req(olie_pkg::OP_INSERT, 1,   -1,             0, 0, 0);  // front
        queue_req(olie_pkg::OP_INSERT, 2,   0,              0, 0, 0);  // middle
        queue_req(olie_pkg::OP_INSERT, 5,   7,              0, 0, 0);  // append
        queue_req(olie_pkg::OP_INSERT, 7,   1,              0, 0, 0);  // past end
        queue_req(olie_pkg::OP_INSERT, 1,   7,              0, 0, 0);  // duplicate ahead
        queue_req(olie_pkg::OP_LOCATE, 0,   7,              0, 0, 0);  // first of two matches
        queue_req(olie_pkg::OP_LOCATE, 0,   32'sh8000_0000, 0, 0, 0);
        queue_req(olie_pkg::OP_LOCATE, 0,   12345,          0, 0, 0);  // absent
        queue_req(olie_pkg::OP_GET,    0,   0,              0, 0, 0);
        queue_req(olie_pkg::OP_GET,    6,   0,              0, 0, 0);  // last word
        queue_req(olie_pkg::OP_GET,    7,   0,              0, 0, 0);  // just past count
        queue_req(olie_pkg::OP_GET,    255, 0,              0, 0, 0);
        queue_req(olie_pkg::OP_DELETE, 0,   0,              0, 0, 0);
        queue_req(olie_pkg::OP_DELETE, 7,   0,              0, 0, 0);
        queue_req(olie_pkg::OP_DELETE, 6,   0,              0, 0, 0);  // last
        queue_req(olie_pkg::OP_DELETE, 1,   0,              0, 0, 0);  // first
        queue_req(olie_pkg::OP_DELETE, 255, 0,              0, 0, 0);
        queue_req(olie_pkg::OP_LOCATE, 255, 0,              0, 0, 0);  // position ignored

        // Fill to capacity, then push eight inserts against the full list
        for (k = 0; k < LIST_CAP + 4; k++)
            queue_req(olie_pkg::OP_INSERT, 0, rand_word(), 1, 0, k == 0);

        // Random blocks: mixed, filling, draining, read heavy
        for (blk = 0; blk < NUM_BLOCKS; blk++) begin
            case (blk % 4)
                0:       begin w_get = 20; w_loc = 20; w_ins = 35; end
                1:       begin w_get = 10; w_loc = 10; w_ins = 70; end
                2:       begin w_get = 10; w_loc = 10; w_ins = 15; end
                default: begin w_get = 35; w_loc = 35; w_ins = 15; end
            endcase
            for (k = 0; k < BLOCK_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    // noise: any op, any position
                    queue_req(olie_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 255),
                              $urandom, 0, 0, k == 0);
                end else begin
                    r  = $urandom_range(0, 99);
                    op = (r < w_get) ? olie_pkg::OP_GET :
                         (r < w_get + w_loc) ? olie_pkg::OP_LOCATE :
                         (r < w_get + w_loc + w_ins) ? olie_pkg::OP_INSERT :
                         olie_pkg::OP_DELETE;
                    queue_req(op, 0, rand_word(), 1,
                              op == olie_pkg::OP_LOCATE && $urandom_range(0, 99) < 60, k == 0);
                end
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go out and every response to come back
        while (req_backlog.size() != 0 || req_beats != req_issued || expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
